FILE: src/kli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kli_pkg: keyframe linear interpolator types
// Item and result structs, item opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package kli_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_EVAL   = 2'd1,
    MODE_CLEAR  = 2'd2
  } kli_mode_e;

  typedef enum logic [1:0] {
    REG_VALUE_MIN   = 2'd0,
    REG_VALUE_MAX   = 2'd1,
    REG_START_VALUE = 2'd2
  } kli_reg_e;

  localparam int unsigned ValW = 32;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [ValW-1:0] target_value;
    logic [ValW-1:0]        segment_ticks;
    logic [ValW-1:0]        elapsed_ticks;
  } kli_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] current_value;
    logic                   value_changed;
    logic                   all_done;
    logic                   list_full;
  } kli_result_t;

endpackage
`default_nettype wire

FILE: src/keyframe_linear_interpolator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top: piecewise linear keyframe animation
// Appends, clears and evaluates a list of linear segments for one value.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; its result shows on
// res_o for one cycle with res_valid_o and cannot be held off. Append, clear
// and unused modes finish at once: the result follows in the next cycle and
// busy_o stays low. An evaluate keeps busy_o high while a small sequencer walks
// the segment memory (a fetch and a compare state per segment passed over),
// then runs one 32x32 multiply and a 32-step restoring divider that yields one
// quotient bit a cycle.
module keyframe_linear_interpolator_top
  import kli_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire kli_item_t   item_i,
  output logic             busy_o,
  output kli_result_t      res_o,
  output logic             res_valid_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [ValW-1:0] cfg_data_i
);

  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned TW = ValW + CW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_CMP   = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [ValW-1:0] vmin_q, vmax_q, vstart_q;
  logic signed [ValW-1:0] stored_q;
  logic [CW-1:0]          count_q;
  logic [TW-1:0]          total_q;

  logic signed [ValW-1:0] tgt_mem [MAX_SEGMENTS];
  logic [ValW-1:0]        dur_mem [MAX_SEGMENTS];
  logic signed [ValW-1:0] rd_tgt_q;
  logic [ValW-1:0]        rd_dur_q;

  logic [CW-1:0]          idx_q;
  logic signed [ValW-1:0] v_q;
  logic [ValW-1:0]        left_q;
  logic [ValW-1:0]        mag_q;
  logic                   neg_q;
  logic                   done_q;
  logic [ValW-1:0]        rem_q;
  logic [ValW-1:0]        lo_q;
  logic [4:0]             step_q;
  logic                   adj_q;

  kli_result_t            res_q;
  logic                   res_valid_q;

  logic                   accept;
  logic                   room;
  logic [CW-1:0]          idx_inc;
  logic signed [ValW:0]   dv;
  logic [ValW:0]          dv_mag;
  logic [2*ValW-1:0]      prod;
  logic [ValW:0]          shifted;
  logic                   q_bit;
  logic [ValW:0]          diff;
  logic signed [ValW:0]   v_adj;
  logic signed [ValW-1:0] clamp_hi, clamp;

  assign accept  = start_i && (state_q == S_IDLE);
  assign room    = count_q < CW'(MAX_SEGMENTS);
  assign idx_inc = idx_q + 1'b1;

  assign dv     = {rd_tgt_q[ValW-1], rd_tgt_q} - {v_q[ValW-1], v_q};
  assign dv_mag = dv[ValW] ? -dv : dv;
  assign prod   = mag_q * left_q;

  // restoring division: remainder always below the divisor
  assign shifted = {rem_q, lo_q[ValW-1]};
  assign q_bit   = shifted >= {1'b0, rd_dur_q};
  assign diff    = shifted - {1'b0, rd_dur_q};

  assign v_adj = neg_q ? ({v_q[ValW-1], v_q} - {1'b0, lo_q})
                       : ({v_q[ValW-1], v_q} + {1'b0, lo_q});

  assign clamp_hi = (v_q > vmax_q) ? vmax_q : v_q;
  assign clamp    = (clamp_hi < vmin_q) ? vmin_q : clamp_hi;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_q   <= {1'b1, {(ValW-1){1'b0}}};
      vmax_q   <= {1'b0, {(ValW-1){1'b1}}};
      vstart_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VALUE_MIN:   vmin_q   <= cfg_data_i;
        REG_VALUE_MAX:   vmax_q   <= cfg_data_i;
        REG_START_VALUE: vstart_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // segment store
  always_ff @(posedge clk_i) begin
    if (accept && item_i.mode == MODE_APPEND && room) begin
      tgt_mem[count_q[IW-1:0]] <= item_i.target_value;
      dur_mem[count_q[IW-1:0]] <= item_i.segment_ticks;
    end
    rd_tgt_q <= tgt_mem[idx_q[IW-1:0]];
    rd_dur_q <= dur_mem[idx_q[IW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && item_i.mode == MODE_EVAL) begin
          state_d = (count_q == '0) ? S_FIN : S_FETCH;
        end
      end
      S_FETCH: state_d = S_CMP;
      S_CMP: begin
        if (rd_dur_q < left_q) begin
          state_d = (idx_inc == count_q) ? S_FIN : S_FETCH;
        end else if (rd_dur_q == '0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (adj_q) state_d = S_FIN;
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      stored_q    <= '0;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
      step_q      <= '0;
      adj_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q <= '0;
            case (item_i.mode)
              MODE_APPEND: begin
                if (room) begin
                  count_q <= count_q + 1'b1;
                  total_q <= total_q + TW'(item_i.segment_ticks);
                end
                res_valid_q <= 1'b1;
              end
              MODE_EVAL: ;
              MODE_CLEAR: begin
                count_q     <= '0;
                total_q     <= '0;
                res_valid_q <= 1'b1;
              end
              default: res_valid_q <= 1'b1;
            endcase
          end
        end
        S_CMP: begin
          if (rd_dur_q < left_q) idx_q <= idx_inc;
        end
        S_MUL: begin
          step_q <= '0;
          adj_q  <= 1'b0;
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == '1) adj_q <= 1'b1;
        end
        S_FIN: begin
          res_valid_q <= 1'b1;
          if (v_q != stored_q) stored_q <= clamp;
        end
        default: ;
      endcase
    end
  end

  // datapath: no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          v_q    <= vstart_q;
          left_q <= item_i.elapsed_ticks;
          done_q <= total_q <= TW'(item_i.elapsed_ticks);
          res_q.current_value <= stored_q;
          res_q.value_changed <= 1'b0;
          res_q.all_done      <= 1'b0;
          res_q.list_full     <= (item_i.mode == MODE_APPEND) && !room;
        end
      end
      S_CMP: begin
        if (rd_dur_q < left_q) begin
          v_q    <= rd_tgt_q;
          left_q <= left_q - rd_dur_q;
        end else if (rd_dur_q == '0) begin
          v_q <= rd_tgt_q;
        end else begin
          mag_q <= dv_mag[ValW-1:0];
          neg_q <= dv[ValW];
        end
      end
      S_MUL: begin
        // quotient fits 32 bits, so the high half is already below the divisor
        rem_q <= prod[2*ValW-1:ValW];
        lo_q  <= prod[ValW-1:0];
      end
      S_DIV: begin
        if (adj_q) begin
          v_q <= v_adj[ValW-1:0];
        end else begin
          rem_q <= q_bit ? diff[ValW-1:0] : shifted[ValW-1:0];
          lo_q  <= {lo_q[ValW-2:0], q_bit};
        end
      end
      S_FIN: begin
        res_q.current_value <= (v_q != stored_q) ? clamp : stored_q;
        res_q.value_changed <= v_q != stored_q;
        res_q.all_done      <= done_q;
        res_q.list_full     <= 1'b0;
      end
      default: ;
    endcase
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond list depth");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < rd_dur_q))
    else $error("divider remainder not below divisor");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (res_valid_o && !busy_o))
    else $error("evaluate finished without a result");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.mode == MODE_EVAL) |=> (busy_o && !res_valid_o))
    else $error("evaluate item did not start the sequencer");

endmodule
`default_nettype wire

FILE: tb/keyframe_linear_interpolator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top_tb: self-checking bench for the interpolator
// Drives append, clear and evaluate items, predicts every result in-bench and
// compares each strobed result field by field.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_top_tb
  import kli_pkg::*;
();

  localparam int unsigned MaxSeg     = 8;
  localparam int          CycleLimit = 1000000;
  localparam int          NumPhases  = 10;
  localparam int          PhaseItems = 100;
  // mode with no meaning and register index with no register behind it
  localparam logic [1:0]  ModeIgnored = 2'd3;
  localparam logic [1:0]  RegUnused   = 2'd3;
  localparam logic signed [31:0] ValLowest  = 32'sh8000_0000;
  localparam logic signed [31:0] ValHighest = 32'sh7FFF_FFFF;

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            start_i    = 1'b0;
  kli_item_t       item_i     = '0;
  logic            cfg_we_i   = 1'b0;
  logic [1:0]      cfg_idx_i  = '0;
  logic [ValW-1:0] cfg_data_i = '0;
  logic            busy_o;
  kli_result_t     res_o;
  logic            res_valid_o;

  // predicted animation state
  logic signed [31:0] clamp_lo   = ValLowest;
  logic signed [31:0] clamp_hi   = ValHighest;
  logic signed [31:0] start_val  = '0;
  logic signed [31:0] held_value = '0;
  logic signed [31:0] seg_target [MaxSeg];
  logic [31:0]        seg_ticks  [MaxSeg];
  int                 seg_count  = 0;

  kli_result_t predicted_frames[$];
  kli_result_t want_frame;
  int          fail_count  = 0;
  int          cycle_count = 0;
  int          items_sent  = 0;
  int          gap_ceiling = 3;
  bit          start_held  = 1'b0;

  keyframe_linear_interpolator_top #(
    .MAX_SEGMENTS(MaxSeg)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_o      (res_o),
    .res_valid_o(res_valid_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("keyframe_linear_interpolator_top_tb failed");
      $finish;
    end
  end

  // value of the curve at an elapsed time, before clamping
  function automatic logic signed [31:0] sample_curve(input logic [31:0] elapsed);
    longint      v;
    longint      dv;
    logic [31:0] left;
    logic [63:0] mag;
    bit          neg;
    bit          landed;
    int          i;
    v = longint'(start_val);
    left = elapsed;
    landed = 1'b0;
    for (i = 0; i < seg_count; i++) begin
      if (!landed) begin
        if (seg_ticks[i] < left) begin
          v = longint'(seg_target[i]);
          left = left - seg_ticks[i];
        end else begin
          dv = longint'(seg_target[i]) - v;
          if (seg_ticks[i] != '0) begin
            neg = dv < 0;
            mag = neg ? 64'(-dv) : 64'(dv);
            mag = (mag * {32'd0, left}) / {32'd0, seg_ticks[i]};
            dv = neg ? -longint'(mag) : longint'(mag);
          end
          v = v + dv;
          landed = 1'b1;
        end
      end
    end
    return v[31:0];
  endfunction

  function automatic kli_result_t advance_animation(input kli_item_t it);
    kli_result_t        frame;
    logic signed [31:0] v;
    logic [63:0]        total;
    int                 i;
    frame = '0;
    case (it.mode)
      MODE_APPEND: begin
        if (seg_count < MaxSeg) begin
          seg_target[seg_count] = it.target_value;
          seg_ticks[seg_count] = it.segment_ticks;
          seg_count++;
        end else begin
          frame.list_full = 1'b1;
        end
      end
      MODE_EVAL: begin
        v = sample_curve(it.elapsed_ticks);
        if (v != held_value) begin
          frame.value_changed = 1'b1;
          // max first, then min: crossed bounds end on value_min
          if (v > clamp_hi) v = clamp_hi;
          if (v < clamp_lo) v = clamp_lo;
          held_value = v;
        end
        total = '0;
        for (i = 0; i < seg_count; i++) total += {32'd0, seg_ticks[i]};
        frame.all_done = (total <= {32'd0, it.elapsed_ticks});
      end
      MODE_CLEAR: seg_count = 0;
      default: ;
    endcase
    frame.current_value = held_value;
    return frame;
  endfunction

  function automatic kli_item_t make_item(input logic [1:0] mode,
                                          input logic signed [31:0] tgt,
                                          input logic [31:0] ticks,
                                          input logic [31:0] elapsed);
    kli_item_t it;
    it.mode = mode;
    it.target_value = tgt;
    it.segment_ticks = ticks;
    it.elapsed_ticks = elapsed;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5, 0))
      0: return ValLowest;
      1: return ValHighest;
      2: return (int'($urandom_range(2000, 0)) - 1000) * 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_ticks();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  // mostly near segment boundaries or inside a segment of the current list
  function automatic logic [31:0] rand_elapsed();
    longint pick;
    int     k;
    int     i;
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: begin
        k = $urandom_range(seg_count, 0);
        pick = 0;
        for (i = 0; i < k; i++) pick += longint'(seg_ticks[i]);
        if (k < seg_count && $urandom_range(1, 0) == 1)
          pick += longint'($urandom_range(seg_ticks[k], 0));
        else
          pick += int'($urandom_range(4, 0)) - 2;
        if (pick < 0) pick = 0;
        if (pick > longint'(32'hFFFF_FFFF)) pick = longint'(32'hFFFF_FFFF);
        return pick[31:0];
      end
    endcase
  endfunction

  // start_i stays high after an item so a back-to-back item needs one update
  task automatic push_item(input kli_item_t it);
    int gap;
    gap = (gap_ceiling == 0) ? 0 : $urandom_range(gap_ceiling, 0);
    if (gap > 0) begin
      if (start_held) start_i <= 1'b0;
      start_held = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    start_held = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted_frames = {predicted_frames, advance_animation(it)};
    if (it.mode != ModeIgnored) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    if (start_held) start_i <= 1'b0;
    start_held = 1'b0;
    @(negedge clk_i);
    while (predicted_frames.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // block must be idle; also pokes the unused index, which must do nothing
  task automatic write_registers(input logic signed [31:0] lo,
                                 input logic signed [31:0] hi,
                                 input logic signed [31:0] st);
    logic [31:0] vals[4];
    logic [1:0]  idx_list[4];
    int          i;
    vals = '{lo, hi, st, $urandom};
    idx_list = '{REG_VALUE_MIN, REG_VALUE_MAX, REG_START_VALUE, RegUnused};
    for (i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx_list[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (idx_list[i])
        REG_VALUE_MIN:   clamp_lo = vals[i];
        REG_VALUE_MAX:   clamp_hi = vals[i];
        REG_START_VALUE: start_val = vals[i];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (predicted_frames.size() == 0) begin
        $error("result strobed with no item outstanding");
        fail_count++;
      end else begin
        want_frame = predicted_frames.pop_front();
        if (res_o.current_value !== want_frame.current_value) begin
          $error("current_value: expected %0d, got %0d",
                 $signed(want_frame.current_value), $signed(res_o.current_value));
          fail_count++;
        end
        if (res_o.value_changed !== want_frame.value_changed) begin
          $error("value_changed: expected %0b, got %0b",
                 want_frame.value_changed, res_o.value_changed);
          fail_count++;
        end
        if (res_o.all_done !== want_frame.all_done) begin
          $error("all_done: expected %0b, got %0b", want_frame.all_done, res_o.all_done);
          fail_count++;
        end
        if (res_o.list_full !== want_frame.list_full) begin
          $error("list_full: expected %0b, got %0b", want_frame.list_full, res_o.list_full);
          fail_count++;
        end
      end
    end
  end

  // empty list gives the start value and is done at any time
  task automatic test_empty_animation();
    push_item(make_item(MODE_EVAL, $urandom, $urandom, '0));
    drain_results();
    write_registers(ValLowest, ValHighest, 32'sd12345 <<< 16);
    push_item(make_item(MODE_EVAL, $urandom, $urandom, '1));
  endtask

  task automatic test_ignored_mode();
    push_item(make_item(ModeIgnored, $urandom, $urandom, $urandom));
  endtask

  // full-scale swing, a zero-length jump, then a maximal segment
  task automatic test_segment_walk();
    push_item(make_item(MODE_CLEAR, $urandom, $urandom, $urandom));
    push_item(make_item(MODE_APPEND, ValHighest, 32'd10, $urandom));
    push_item(make_item(MODE_APPEND, ValLowest, '0, $urandom));
    push_item(make_item(MODE_APPEND, '0, '1, $urandom));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, 32'd5));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, 32'd10));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, 32'd11));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, 32'd12));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, '1));
  endtask

  // fill up with maximal durations: the total passes 32 bits
  task automatic test_full_list();
    int i;
    for (i = 0; i < 5; i++)
      push_item(make_item(MODE_APPEND, (i % 2) ? ValLowest : ValHighest, '1, $urandom));
    push_item(make_item(MODE_APPEND, $urandom, $urandom, $urandom));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, '1));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, 32'hC000_0000));
  endtask

  task automatic test_crossed_bounds();
    drain_results();
    write_registers(32'sd100, -32'sd100, -32'sd7 <<< 16);
    push_item(make_item(MODE_EVAL, $urandom, $urandom, 32'd3));
    drain_results();
    write_registers(ValLowest, ValHighest, ValHighest);
    push_item(make_item(MODE_EVAL, $urandom, $urandom, 32'd3));
  endtask

  // clearing keeps the stored value
  task automatic test_clear_list();
    push_item(make_item(MODE_CLEAR, $urandom, $urandom, $urandom));
    push_item(make_item(MODE_EVAL, $urandom, $urandom, '0));
  endtask

  task automatic play_sequence();
    int n;
    int i;
    if ($urandom_range(3, 0) != 0)
      push_item(make_item(MODE_CLEAR, $urandom, $urandom, $urandom));
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(MaxSeg + 2, MaxSeg + 1)
                                    : $urandom_range(MaxSeg, 1);
    for (i = 0; i < n; i++)
      push_item(make_item(MODE_APPEND, rand_value(), rand_ticks(), $urandom));
    n = $urandom_range(6, 2);
    for (i = 0; i < n; i++)
      push_item(make_item(MODE_EVAL, $urandom, $urandom, rand_elapsed()));
  endtask

  task automatic test_random_phases();
    logic signed [31:0] a;
    logic signed [31:0] b;
    int                 phase;
    int                 stop_at;
    for (phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      a = $urandom;
      b = $urandom;
      case (phase % 5)
        0: write_registers(ValLowest, ValHighest, rand_value());
        1: write_registers((a < b) ? a : b, (a < b) ? b : a, rand_value());
        2: write_registers((a < b) ? b : a, (a < b) ? a : b, rand_value());
        3: write_registers(a, a, rand_value());
        default: write_registers(-$signed(32'($urandom_range(1 << 22, 0))),
                                 $signed(32'($urandom_range(1 << 22, 0))),
                                 $urandom_range(1, 0) ? ValLowest : ValHighest);
      endcase
      gap_ceiling = (phase % 3 == 1) ? 0 : 11;
      stop_at = items_sent + PhaseItems;
      while (items_sent < stop_at) begin
        if ($urandom_range(4, 0) != 0)
          play_sequence();
        else
          push_item(make_item(2'($urandom_range(3, 0)), $urandom, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_animation();
    test_ignored_mode();
    test_segment_walk();
    test_full_list();
    test_crossed_bounds();
    test_clear_list();
    test_random_phases();
    drain_results();
    // the idle tail outlasts the longest evaluate
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && predicted_frames.size() == 0) begin
      $display("keyframe_linear_interpolator_top_tb passed");
    end else begin
      $display("keyframe_linear_interpolator_top_tb failed");
    end
    $finish;
  end

endmodule
